// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/setm_pkg.sv =====
// ----------------------------------------------------------------------------
// setm_pkg
// Constants and types for the scope edge trigger and measurement block.
// ----------------------------------------------------------------------------
`default_nettype none

package setm_pkg;

  // record geometry
  localparam int RECORD_LENGTH = 32768;
  localparam int WINDOW_HIGH   = 1000;
  localparam int WINDOW_LOW    = 5;

  localparam int SIDX_W = $clog2(RECORD_LENGTH);  // sample index counter
  localparam int EDGE_W = 15;                     // reported edge index
  localparam int CODE_W = 8;                      // ADC code

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_LEVEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_SOURCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_SLOPE  = 2'd2;

  localparam logic [CODE_W-1:0] LEVEL_RESET  = 8'd141;
  localparam logic              SOURCE_RESET = 1'b0;
  localparam logic              SLOPE_RESET  = 1'b1;

  localparam logic SLOPE_RISING  = 1'b0;
  localparam logic SLOPE_FALLING = 1'b1;

  localparam logic [CODE_W-1:0] CODE_MIN = '0;
  localparam logic [CODE_W-1:0] CODE_MAX = '1;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 80;

  // result word, first member in the top bits
  typedef struct packed {
    logic [CODE_W-1:0] span_b;
    logic [CODE_W-1:0] max_b;
    logic [CODE_W-1:0] min_b;
    logic [CODE_W-1:0] span_a;
    logic [CODE_W-1:0] max_a;
    logic [CODE_W-1:0] min_a;
    logic [EDGE_W-1:0] period_samples;
    logic              period_valid;
    logic [EDGE_W-1:0] trigger_index;
    logic              trigger_found;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/scope_edge_trigger_and_measure.sv =====
// ----------------------------------------------------------------------------
// scope_edge_trigger_and_measure
// Edge trigger search and min/max/peak-to-peak measurement over one record.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one sample pair per word: tdata = {sample_b, sample_a},
//   tlast marks the final pair of a record. Indices count from 0 per record.
//   m_* carries one result word per record, issued for the tlast word only.
//   cfg_* writes trigger_level (0), trigger_source (1), trigger_slope (2);
//   write only while no record is in flight.
// Timing:
//   One pair is accepted per cycle while s_tready is high. The per-pair update
//   (edge test, running min/max) is a single compare stage between the record
//   state and the result register; the result for a tlast word is registered
//   into the result register, or into the skid buffer while the receiver stalls.
// Stall:
//   A result register plus a one-word skid buffer sit on the output. While
//   the receiver stalls, sample words keep flowing; s_tready drops only when
//   both output slots hold results.
// Reset:
//   rst (sync, active high) clears record state, empties the output and
//   loads level 141, source channel A, falling slope.
// ----------------------------------------------------------------------------
`default_nettype none

module scope_edge_trigger_and_measure (
  input  wire                          clk,
  input  wire                          rst,
  // fields from bit 0: sample_a[7:0], sample_b[15:8]
  input  wire [setm_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire                          s_tvalid,
  input  wire                          s_tlast,
  output logic                         s_tready,
  // fields from bit 0: trigger_found, trigger_index[15:1], period_valid[16],
  // period_samples[31:17], min_a, max_a, span_a, min_b, max_b, span_b
  output logic [setm_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                         m_tvalid,
  input  wire                          m_tready,
  input  wire                          cfg_we,
  input  wire [setm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [setm_pkg::CODE_W-1:0]    cfg_data
);
  import setm_pkg::*;

  // configuration
  logic [CODE_W-1:0] trigger_level;
  logic              trigger_source;
  logic              trigger_slope;

  // record state
  logic [SIDX_W-1:0] sample_index;
  logic [CODE_W-1:0] hist0, hist1;       // s[i], s[i+1]
  logic [EDGE_W-1:0] latest_edge, earlier_edge;
  logic [1:0]        edge_count;
  logic [CODE_W-1:0] min_a, max_a, min_b, max_b;

  // next values
  logic [SIDX_W-1:0] sample_index_next;
  logic [EDGE_W-1:0] latest_edge_next, earlier_edge_next;
  logic [1:0]        edge_count_next;
  logic [CODE_W-1:0] min_a_next, max_a_next, min_b_next, max_b_next;

  logic [CODE_W-1:0] sample_a, sample_b, cur;
  logic [SIDX_W-1:0] edge_pos;
  logic [31:0]       edge_pos_w, index_w;
  logic              in_window, edge_hit;
  logic              accept, emit;
  result_t           res_word;

  // output buffering
  logic [OUT_DATA_W-1:0] out_data, skid_data;
  logic                  out_valid, skid_valid;

  assign sample_a = s_tdata[CODE_W-1:0];
  assign sample_b = s_tdata[2*CODE_W-1:CODE_W];

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign emit     = accept && s_tlast;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // configuration writes; indexes past the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_level  <= LEVEL_RESET;
      trigger_source <= SOURCE_RESET;
      trigger_slope  <= SLOPE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRIGGER_LEVEL:  trigger_level  <= cfg_data;
        REG_TRIGGER_SOURCE: trigger_source <= cfg_data[0];
        REG_TRIGGER_SLOPE:  trigger_slope  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // per-pair update
  always_comb begin
    cur = trigger_source ? sample_b : sample_a;

    // edge at i = index - 2, tested once s[i+2] arrives
    edge_pos   = sample_index - SIDX_W'(2);
    index_w    = 32'(sample_index);
    edge_pos_w = 32'(edge_pos);
    in_window  = (index_w >= 32'd2) &&
                 (edge_pos_w >= 32'(WINDOW_LOW)) &&
                 (edge_pos_w <= 32'(WINDOW_HIGH));

    if (trigger_slope == SLOPE_RISING) begin
      edge_hit = (hist0 < trigger_level) && (hist1 >= trigger_level) && (cur >= hist1);
    end else begin
      edge_hit = (hist0 > trigger_level) && (hist1 <= trigger_level) && (cur <= hist1);
    end
    edge_hit = edge_hit && in_window;

    latest_edge_next  = latest_edge;
    earlier_edge_next = earlier_edge;
    edge_count_next   = edge_count;
    if (edge_hit) begin
      earlier_edge_next = latest_edge;
      latest_edge_next  = EDGE_W'(edge_pos);
      if (edge_count != 2'd2) begin
        edge_count_next = edge_count + 2'd1;
      end
    end

    // overlong records hold the index at the end of the record
    if (index_w < 32'(RECORD_LENGTH - 1)) begin
      sample_index_next = sample_index + SIDX_W'(1);
    end else begin
      sample_index_next = sample_index;
    end

    min_a_next = (sample_a < min_a) ? sample_a : min_a;
    max_a_next = (sample_a > max_a) ? sample_a : max_a;
    min_b_next = (sample_b < min_b) ? sample_b : min_b;
    max_b_next = (sample_b > max_b) ? sample_b : max_b;

    res_word.trigger_found  = (edge_count_next != 2'd0);
    res_word.trigger_index  = (edge_count_next != 2'd0) ? latest_edge_next : '0;
    res_word.period_valid   = (edge_count_next == 2'd2);
    res_word.period_samples = (edge_count_next == 2'd2) ?
                              (latest_edge_next - earlier_edge_next) : '0;
    res_word.min_a  = min_a_next;
    res_word.max_a  = max_a_next;
    res_word.span_a = max_a_next - min_a_next;
    res_word.min_b  = min_b_next;
    res_word.max_b  = max_b_next;
    res_word.span_b = max_b_next - min_b_next;
  end

  // record state; the tlast word restarts the record
  always_ff @(posedge clk) begin
    if (rst || emit) begin
      sample_index <= '0;
      hist0        <= '0;
      hist1        <= '0;
      latest_edge  <= '0;
      earlier_edge <= '0;
      edge_count   <= '0;
      min_a        <= CODE_MAX;
      min_b        <= CODE_MAX;
      max_a        <= CODE_MIN;
      max_b        <= CODE_MIN;
    end else if (accept) begin
      sample_index <= sample_index_next;
      hist0        <= hist1;
      hist1        <= cur;
      latest_edge  <= latest_edge_next;
      earlier_edge <= earlier_edge_next;
      edge_count   <= edge_count_next;
      min_a        <= min_a_next;
      max_a        <= max_a_next;
      min_b        <= min_b_next;
      max_b        <= max_b_next;
    end
  end

  // result register with one-word skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        // s_tready is low here, so no new result competes
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= emit;
        if (emit) begin
          out_data <= res_word;
        end
      end
    end else if (emit) begin
      skid_valid <= 1'b1;
      skid_data  <= res_word;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/setm_checker.sv =====
// ----------------------------------------------------------------------------
// setm_checker
// Port-level checks for the scope edge trigger block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module setm_checker (
  input wire                             clk,
  input wire                             rst,
  input wire [setm_pkg::IN_DATA_W-1:0]   s_tdata,
  input wire                             s_tvalid,
  input wire                             s_tlast,
  input wire                             s_tready,
  input wire [setm_pkg::OUT_DATA_W-1:0]  m_tdata,
  input wire                             m_tvalid,
  input wire                             m_tready,
  input wire                             cfg_we,
  input wire [setm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input wire [setm_pkg::CODE_W-1:0]      cfg_data
);
  import setm_pkg::*;

  result_t r;
  logic    unused_in;

  assign r = m_tdata;
  assign unused_in = ^{s_tdata, s_tvalid, s_tlast, s_tready, cfg_we, cfg_index, cfg_data};

  // stalled result holds
  `ASSERT_CLK(a_stall_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

  // reset empties the output
  `ASSERT_CLK_ALWAYS(a_reset_empty, clk, rst |=> !m_tvalid, "result valid after reset")

  // period only with an edge; unused fields zero
  `ASSERT_CLK(a_period_found, clk, rst, m_tvalid |-> (r.trigger_found || !r.period_valid) && (r.period_valid || r.period_samples == '0) && (r.trigger_found || r.trigger_index == '0), "edge flags inconsistent")

  // every record has at least one pair
  `ASSERT_CLK(a_min_le_max, clk, rst, m_tvalid |-> r.min_a <= r.max_a && r.min_b <= r.max_b, "min above max")

  // span is max minus min
  `ASSERT_CLK(a_span, clk, rst, m_tvalid |-> r.span_a == CODE_W'(r.max_a - r.min_a) && r.span_b == CODE_W'(r.max_b - r.min_b), "span mismatch")

endmodule

bind scope_edge_trigger_and_measure setm_checker u_setm_checker (.*);

`default_nettype wire
